[rtl/tmpl_pkg.sv]
// Shared types and constants for the trimmed-mean proximity lock.
// Used by tmpl_cell, tmpl_div and trimmed_mean_proximity_lock; depends on nothing.
package tmpl_pkg;

  localparam int DATA_W = 16;
  localparam int LOST_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW_DEFAULT = 20;
  // Two largest and two smallest entries are dropped from the window.
  localparam int TRIM_COUNT = 4;

  localparam logic [DATA_W-1:0] RESET_LAST_VALID = 16'd5000;
  localparam logic [DATA_W-1:0] RESET_UNLOCK_THR = 16'd300;
  localparam logic [DATA_W-1:0] RESET_LOCK_THR = 16'd1000;
  localparam logic [DATA_W-1:0] RESET_HOLD_DIST = 16'd800;
  localparam logic [LOST_W-1:0] RESET_LOST_LIMIT = 4'd6;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } servo_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNLOCK_THR = 2'd0,
    CFG_LOCK_THR   = 2'd1,
    CFG_HOLD_DIST  = 2'd2,
    CFG_LOST_LIMIT = 2'd3
  } cfg_idx_e;

endpackage

[rtl/trimmed_mean_proximity_lock.sv]
// Top level of the trimmed-mean proximity lock: window cell chain, running
// statistics, lock decision and stream ports. Depends on tmpl_pkg, tmpl_cell, tmpl_div.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  raw_distance
//   m_axis    out        m_axis_tvalid / m_axis_tready  filtered_distance, servo_command,
//                                                       is_locked
//   cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// A non-zero sample with the window full takes the full path: the cell chain
// rotates once through the statistics accumulator, entry by entry,
// followed by the trim and the three-stage divider.
// Lost samples and samples before the window has filled go straight to the output.
// Reset needs no clearing pass; window cells are read only after all were written.
// A finished result waits in the output register; the next sample is taken
// meanwhile and completes once that result has been taken.
module trimmed_mean_proximity_lock
  import tmpl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [15:0] raw_distance
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [15:0] filtered_distance,
                                               // [17:16] servo_command, [18] is_locked
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = DATA_W + $clog2(WINDOW);
  localparam int OUT_PAD = 24 - DATA_W - 3;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [DATA_W-1:0] unlock_thr_q, lock_thr_q, hold_dist_q;
  logic [LOST_W-1:0] lost_limit_q;

  // control state
  logic [CNT_W-1:0]  wr_idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ring_full_q;
  logic [LOST_W-1:0] lost_q;
  logic [DATA_W-1:0] last_valid_q;
  logic              locked_q;
  logic              raw_zero_q;

  // payload
  logic [DATA_W-1:0] dist_q;
  logic [SUM_W-1:0]  sum_q;
  logic [DATA_W-1:0] hi1_q, hi2_q, lo1_q, lo2_q;

  logic              in_acc;
  logic              raw_zero;
  logic              full_next;
  logic              out_free;
  logic              load;
  logic              rotate;
  logic [DATA_W-1:0] cell_data [WINDOW];
  logic [DATA_W-1:0] tail;
  logic [SUM_W-1:0]  trim_num;
  logic              div_valid;
  logic [DATA_W-1:0] div_quot;

  logic [DATA_W-1:0] hi1_d, hi2_d, lo1_d, lo2_d;

  logic [LOST_W-1:0] dec_lost;
  logic [DATA_W-1:0] dec_last;
  logic [DATA_W-1:0] dec_dist;
  logic              dec_locked;
  servo_cmd_e        dec_cmd;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign raw_zero  = (s_axis_tdata == '0);
  assign full_next = ring_full_q || (wr_idx_q == LAST_IDX);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign load      = in_acc && !raw_zero;
  assign rotate    = (state_q == ST_ROTATE);
  assign tail      = cell_data[WINDOW-1];

  // Window chain: new samples push in at the head, the oldest drops out the
  // tail; a rotation feeds the tail back to the head.
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic [DATA_W-1:0] cell_in;
    if (g == 0) begin : g_head
      assign cell_in = load ? s_axis_tdata : tail;
    end else begin : g_link
      assign cell_in = cell_data[g-1];
    end
    tmpl_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (load || rotate),
      .data_i     (cell_in),
      .data_o     (cell_data[g])
    );
  end

  // Running two largest and two smallest, counted with multiplicity.
  always_comb begin
    hi1_d = hi1_q;
    hi2_d = hi2_q;
    lo1_d = lo1_q;
    lo2_d = lo2_q;
    if (tail > hi1_q) begin
      hi2_d = hi1_q;
      hi1_d = tail;
    end else if (tail > hi2_q) begin
      hi2_d = tail;
    end
    if (tail < lo1_q) begin
      lo2_d = lo1_q;
      lo1_d = tail;
    end else if (tail < lo2_q) begin
      lo2_d = tail;
    end
  end

  assign trim_num = sum_q - SUM_W'(hi1_q) - SUM_W'(hi2_q) - SUM_W'(lo1_q) - SUM_W'(lo2_q);

  tmpl_div #(
    .NUM_W   (SUM_W),
    .DIVISOR (WINDOW - TRIM_COUNT)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == ST_TRIM),
    .num_i   (trim_num),
    .valid_o (div_valid),
    .quot_o  (div_quot)
  );

  // Lock decision for the finished sample.
  always_comb begin
    logic [LOST_W:0] lost_inc;
    lost_inc   = (LOST_W+1)'(lost_q) + (LOST_W+1)'(1);
    dec_lost   = lost_q;
    dec_last   = last_valid_q;
    dec_dist   = dist_q;
    dec_locked = locked_q;
    dec_cmd    = CMD_NONE;
    if (raw_zero_q) begin
      if (!locked_q && (last_valid_q < hold_dist_q)) begin
        dec_lost = '0;
        dec_dist = last_valid_q;
      end else begin
        dec_dist = '0;
        if (lost_inc >= {1'b0, lost_limit_q}) begin
          if (!locked_q) begin
            dec_cmd    = CMD_CLOSE;
            dec_locked = 1'b1;
          end
          dec_lost = lost_limit_q;
        end else begin
          dec_lost = lost_inc[LOST_W-1:0];
        end
      end
    end else begin
      dec_lost = '0;
      dec_last = dist_q;
    end
    if (dec_dist != '0) begin
      if ((dec_dist <= unlock_thr_q) && dec_locked) begin
        dec_cmd    = CMD_OPEN;
        dec_locked = 1'b0;
      end else if ((dec_dist > lock_thr_q) && !dec_locked) begin
        dec_cmd    = CMD_CLOSE;
        dec_locked = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_thr_q <= RESET_UNLOCK_THR;
      lock_thr_q   <= RESET_LOCK_THR;
      hold_dist_q  <= RESET_HOLD_DIST;
      lost_limit_q <= RESET_LOST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UNLOCK_THR: unlock_thr_q <= cfg_data_i;
        CFG_LOCK_THR:   lock_thr_q   <= cfg_data_i;
        CFG_HOLD_DIST:  hold_dist_q  <= cfg_data_i;
        CFG_LOST_LIMIT: lost_limit_q <= cfg_data_i[LOST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wr_idx_q      <= '0;
      cnt_q         <= '0;
      ring_full_q   <= 1'b0;
      lost_q        <= '0;
      last_valid_q  <= RESET_LAST_VALID;
      locked_q      <= 1'b1;
      raw_zero_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      // Drop the taken result unless a new one goes out this cycle
      if (m_axis_tready && !((state_q == ST_DONE) && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            raw_zero_q <= raw_zero;
            cnt_q      <= '0;
            if (raw_zero) begin
              state_q <= ST_DONE;
            end else begin
              wr_idx_q    <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + CNT_W'(1);
              ring_full_q <= full_next;
              state_q     <= full_next ? ST_ROTATE : ST_DONE;
            end
          end
        end
        ST_ROTATE: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == LAST_IDX) begin
            state_q <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_valid) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            lost_q        <= dec_lost;
            last_valid_q  <= dec_last;
            locked_q      <= dec_locked;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {OUT_PAD'(0), dec_locked, dec_cmd, dec_dist};
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dist_q <= s_axis_tdata;
      sum_q  <= '0;
      hi1_q  <= '0;
      hi2_q  <= '0;
      lo1_q  <= '1;
      lo2_q  <= '1;
    end else if (rotate) begin
      sum_q <= sum_q + SUM_W'(tail);
      hi1_q <= hi1_d;
      hi2_q <= hi2_d;
      lo1_q <= lo1_d;
      lo2_q <= lo2_d;
    end else if ((state_q == ST_DIV) && div_valid) begin
      dist_q <= div_quot;
    end
  end

  // One sample in flight: the port closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid |-> (state_q == ST_DIV))
    else $error("divider result outside the divide wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[17:16] == CMD_OPEN)) |-> !m_axis_tdata[18])
    else $error("open command with lock still closed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[17:16] == CMD_CLOSE)) |-> m_axis_tdata[18])
    else $error("close command with lock left open");

endmodule

[rtl/tmpl_cell.sv]
// One storage cell of the sample window chain.
// Loads its neighbor's value when the chain shifts; depends on tmpl_pkg.
module tmpl_cell
  import tmpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              shift_en_i,
  input  logic [DATA_W-1:0] data_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

[rtl/tmpl_div.sv]
// Three-stage pipelined division by a fixed divisor (reciprocal multiply,
// then one correction step). Depends on tmpl_pkg.
module tmpl_div
  import tmpl_pkg::*;
#(
  parameter int NUM_W   = 21,
  parameter int DIVISOR = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int MW = NUM_W + 1;
  localparam int DW = $clog2(DIVISOR + 1);
  localparam longint unsigned RECIP_VAL = (64'd1 << NUM_W) / DIVISOR;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_VAL);
  localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);
  localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

  logic [NUM_W+MW-1:0] prod_q;
  logic [NUM_W-1:0]    num1_q, num2_q;
  logic [NUM_W-1:0]    q0_q;
  logic [NUM_W+DW-1:0] qd_q;
  logic [NUM_W-1:0]    q0_c;
  logic [NUM_W-1:0]    rem_c;
  logic [NUM_W-1:0]    quot_c;
  logic [DATA_W-1:0]   quot_q;
  logic                v1_q, v2_q, v3_q;

  // The estimate is low by at most one; the remainder tells which.
  assign q0_c   = prod_q[NUM_W +: NUM_W];
  assign rem_c  = num2_q - qd_q[NUM_W-1:0];
  assign quot_c = (rem_c >= DIV_N) ? q0_q + NUM_W'(1) : q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{MW{1'b0}}, num_i} * {{NUM_W{1'b0}}, RECIP};
    num1_q <= num_i;
    q0_q   <= q0_c;
    qd_q   <= {{DW{1'b0}}, q0_c} * {{NUM_W{1'b0}}, DIV_C};
    num2_q <= num1_q;
    quot_q <= quot_c[DATA_W-1:0];
  end

  assign valid_o = v3_q;
  assign quot_o  = quot_q;

endmodule

[tb/testbench.sv]
// Self-checking bench for trimmed_mean_proximity_lock: a queue-fed stream driver,
// a result monitor and an in-bench predictor of filter, hold and lock hysteresis.
// Depends on tmpl_pkg and the RTL top level only.
module testbench
  import tmpl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = WINDOW_DEFAULT;

  // Opening run at reset settings: lost while locked, pass-through extremes,
  // open at the unlock threshold, hold of a short distance while open, close
  // just above the lock threshold, then a lost run long enough to force a close.
  localparam logic [DATA_W-1:0] OPENING_RUN [14] = '{
    16'd0, 16'd65535, 16'd300, 16'd0, 16'd1001, 16'd1, 16'd1000,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd300
  };

  typedef struct packed {
    logic [DATA_W-1:0] distance;
    servo_cmd_e        command;
    logic              locked;
  } lock_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;   // [15:0] raw_distance
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;        // [15:0] filtered_distance,
                                             // [17:16] servo_command, [18] is_locked
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  logic [DATA_W-1:0] pending [$];
  lock_result_t      expected_results [$];
  lock_result_t      want_result;
  int                mismatches = 0;
  int                results_seen = 0;
  int                random_items = 0;
  int unsigned       cycle_count = 0;

  // Predictor state and its copy of the limits
  int thr_open  = int'(RESET_UNLOCK_THR);
  int thr_close = int'(RESET_LOCK_THR);
  int hold_max  = int'(RESET_HOLD_DIST);
  int lost_max  = int'(RESET_LOST_LIMIT);
  int win_samples [WINDOW];
  int win_pos = 0;
  bit win_filled = 1'b0;
  int lost_run = 0;
  int last_good = int'(RESET_LAST_VALID);
  bit lock_closed = 1'b1;

  trimmed_mean_proximity_lock #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // No idling at all inside one long stretch of the run
  function automatic bit take_break();
    if (cycle_count >= 10000 && cycle_count < 20000) return 1'b0;
    return $urandom_range(0, 99) < 21;
  endfunction

  function automatic logic [DATA_W-1:0] clip_distance(int v);
    if (v < 1) return DATA_W'(1);
    if (v > 65535) return '1;
    return DATA_W'(v);
  endfunction

  // Store a sample; until the window has wrapped once the sample passes through
  function automatic int window_mean(int sample);
    int ordered [$];
    int total;
    win_samples[win_pos] = sample;
    win_pos++;
    if (win_pos == WINDOW) begin
      win_pos = 0;
      win_filled = 1'b1;
    end
    if (!win_filled) return sample;
    foreach (win_samples[i]) ordered.push_back(win_samples[i]);
    ordered.sort();
    // drop the two smallest and two largest, duplicates counted
    total = 0;
    for (int i = 2; i < WINDOW - 2; i++) total += ordered[i];
    return total / (WINDOW - 4);
  endfunction

  function automatic lock_result_t track_distance(logic [DATA_W-1:0] raw);
    lock_result_t r;
    int level;
    r.command = CMD_NONE;
    level = 0;
    if (raw == '0) begin
      if (!lock_closed && last_good < hold_max) begin
        lost_run = 0;
        level = last_good;
      end else begin
        lost_run++;
        if (lost_run >= lost_max) begin
          if (!lock_closed) begin
            r.command = CMD_CLOSE;
            lock_closed = 1'b1;
          end
          lost_run = lost_max;
        end
      end
    end else begin
      lost_run = 0;
      level = window_mean(int'(raw));
      last_good = level;
    end
    if (level > 0) begin
      if (level <= thr_open && lock_closed) begin
        r.command = CMD_OPEN;
        lock_closed = 1'b0;
      end else if (level > thr_close && !lock_closed) begin
        r.command = CMD_CLOSE;
        lock_closed = 1'b1;
      end
    end
    r.distance = DATA_W'(level);
    r.locked = lock_closed;
    return r;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("%0t: result %0d %s got %0d want %0d", $time, results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    logic [DATA_W-1:0] word;
    word = DATA_W'(value);
    // upper bits of the lost limit write are junk the block must drop
    if (idx == CFG_LOST_LIMIT) begin
      word = DATA_W'($urandom);
      word[LOST_W-1:0] = LOST_W'(value);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_UNLOCK_THR: thr_open = int'(word);
      CFG_LOCK_THR:   thr_close = int'(word);
      CFG_HOLD_DIST:  hold_max = int'(word);
      CFG_LOST_LIMIT: lost_max = int'(word[LOST_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_limits(int unlock_mm, int lock_mm, int hold_mm, int lost_lim);
    write_reg(CFG_UNLOCK_THR, unlock_mm);
    write_reg(CFG_LOCK_THR, lock_mm);
    write_reg(CFG_HOLD_DIST, hold_mm);
    write_reg(CFG_LOST_LIMIT, lost_lim);
  endtask

  // Mostly runs of similar distances around the current limits so the trimmed
  // mean actually crosses them, plus lost runs, raw noise, and all-ones values each followed by a single-bit value.
  task automatic queue_bursts(int count);
    int added;
    int kind;
    int span;
    int center;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        center = (kind < 30) ? thr_open : (kind < 55) ? thr_close : hold_max;
        center += int'($urandom_range(0, 160)) - 80;
        span = $urandom_range(6, 24);
        repeat (span) pending.push_back(clip_distance(center + int'($urandom_range(0, 40)) - 20));
      end else if (kind < 85) begin
        span = $urandom_range(1, 18);
        repeat (span) pending.push_back('0);
      end else if (kind < 95) begin
        span = $urandom_range(1, 6);
        repeat (span) pending.push_back(DATA_W'($urandom));
      end else begin
        span = 2;
        pending.push_back('1);
        pending.push_back(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
      end
      added += span;
    end
    random_items += added;
  endtask

  task automatic settle();
    while (pending.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int pick_limit(int lo, int hi, int typ_lo, int typ_hi);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return lo;
    if (roll < 4) return hi;
    return $urandom_range(typ_lo, typ_hi);
  endfunction

  // Driver: hold an offered transaction until taken, then predict its result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(track_distance(s_axis_tdata));
        pending.delete(0);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold
      end else if (pending.size() > 0 && !take_break()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected transaction", int'(m_axis_tdata), -1);
        end else begin
          want_result = expected_results.pop_front();
          if (m_axis_tdata[15:0] !== want_result.distance)
            flag_mismatch("filtered_distance", int'(m_axis_tdata[15:0]),
                          int'(want_result.distance));
          if (m_axis_tdata[17:16] !== want_result.command)
            flag_mismatch("servo_command", int'(m_axis_tdata[17:16]),
                          int'(want_result.command));
          if (m_axis_tdata[18] !== want_result.locked)
            flag_mismatch("is_locked", int'(m_axis_tdata[18]), int'(want_result.locked));
        end
        results_seen++;
      end
      m_axis_tready <= !take_break();
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (OPENING_RUN[i]) pending.push_back(OPENING_RUN[i]);
    // fill the window with repeats so the trim sees equal entries
    repeat (14) pending.push_back(16'd700);
    settle();

    // lost limit of zero: the first unheld lost sample closes
    set_limits(int'(RESET_UNLOCK_THR), int'(RESET_LOCK_THR), 0, 0);
    repeat (3) pending.push_back('0);
    queue_bursts(80);
    settle();

    set_limits(65535, 0, 65535, 15);
    queue_bursts(100);
    settle();

    set_limits(0, 65535, 0, 1);
    queue_bursts(100);
    settle();

    while (random_items < 1600) begin
      set_limits(pick_limit(0, 65535, 50, 1500), pick_limit(0, 65535, 200, 4000),
                 pick_limit(0, 65535, 0, 3000), pick_limit(0, 15, 1, 15));
      queue_bursts(100);
      settle();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

[trimmed_mean_proximity_lock.f]
rtl/tmpl_pkg.sv
rtl/tmpl_cell.sv
rtl/tmpl_div.sv
rtl/trimmed_mean_proximity_lock.sv
tb/testbench.sv
